@@ rtl/vccm_pkg.sv @@
package vccm_pkg;

	localparam int TAG_W = 64;
	localparam int CNT_W = 64;
	localparam int SIZE_W = 5;

	typedef enum logic [1:0] {
		FUNC_RESTART = 2'd0,
		FUNC_INCR    = 2'd1,
		FUNC_REMOTE  = 2'd2,
		FUNC_FINISH  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ORDER_EQUAL      = 2'd0,
		ORDER_BEFORE     = 2'd1,
		ORDER_AFTER      = 2'd2,
		ORDER_CONCURRENT = 2'd3
	} order_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		func_t              func;
		logic [TAG_W-1:0]   node_tag;
		logic [CNT_W-1:0]   remote_count;
		logic               merge;
	} req_t;

	typedef struct packed {
		logic               status;
		order_t             order;
		logic [CNT_W-1:0]   entry_count;
		logic [SIZE_W-1:0]  clock_size;
	} rsp_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		func_t              func;
		logic [TAG_W-1:0]   tag;
		logic [CNT_W-1:0]   rc;
		logic               merge;
		logic [TAG_W-1:0]   local_tag;
		logic               upd;
		logic               append;
	} cell_ctl_t;

	// passed from cell to cell along the row
	typedef struct packed {
		logic               hit;
		logic [CNT_W-1:0]   cnt;
		logic               unnamed_nz;
	} chain_t;

endpackage

@@ rtl/vccm_cell.sv @@
module vccm_cell #(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vccm_pkg::cell_ctl_t ctl,
	input  logic [CW-1:0]       used,
	input  vccm_pkg::chain_t    chain_in,
	output vccm_pkg::chain_t    chain_out
);
	import vccm_pkg::*;

	logic [TAG_W-1:0] tag_q;
	logic [CNT_W-1:0] cnt_q;
	logic             named_q;
	logic             valid;
	logic             hit;
	logic             append_here;
	logic [CNT_W-1:0] cnt_inc;

	assign valid       = CW'(IDX) < used;
	assign hit         = valid && (tag_q == ctl.tag);
	assign append_here = ctl.append && (used == CW'(IDX));
	assign cnt_inc     = (cnt_q == '1) ? cnt_q : cnt_q + CNT_W'(1);

	// pass match and unnamed-nonzero info down the row
	assign chain_out.hit        = chain_in.hit | hit;
	assign chain_out.cnt        = chain_in.cnt | (hit ? cnt_q : '0);
	assign chain_out.unnamed_nz = chain_in.unnamed_nz | (valid && !named_q && (cnt_q != '0));

	always_ff @(posedge clk) begin
		if (ctl.upd) begin
			case (ctl.func)
				FUNC_RESTART: begin
					if (IDX == 0) begin
						tag_q <= ctl.local_tag;
						cnt_q <= CNT_W'(1);
					end
				end
				FUNC_INCR: begin
					if (hit) begin
						cnt_q <= cnt_inc;
					end else if (append_here) begin
						tag_q <= ctl.tag;
						cnt_q <= CNT_W'(1);
					end
				end
				FUNC_REMOTE: begin
					if (hit) begin
						if (ctl.merge && (ctl.rc > cnt_q)) begin
							cnt_q <= ctl.rc;
						end
					end else if (append_here) begin
						tag_q <= ctl.tag;
						cnt_q <= ctl.rc;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			named_q <= 1'b0;
		end else if (ctl.upd) begin
			case (ctl.func)
				FUNC_RESTART, FUNC_FINISH: begin
					named_q <= 1'b0;
				end
				FUNC_REMOTE: begin
					if (hit || append_here) begin
						named_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ rtl/vector_clock_compare_merge.sv @@
// Vector clock compare and merge. Holds one local vector clock of up to MAX_NODES
// (64-bit tag, 64-bit count) entries in a row of cells, one entry per cell. Each
// item passes through an evaluate cycle in which every cell matches the item's
// tag and the row hands the matched count and an unnamed-nonzero flag from cell to
// cell, and an update cycle that writes the cells and loads the result register.
// A new item is taken in the update cycle of the previous one, so the block takes
// the next item before it is through with the last; the update stalls only when a
// result is due and the result register holds an item not yet taken.
// Restart, increment and finish each produce one result item; a remote entry
// produces none. The local node tag is written through the cfg port (always ready)
// and must only be written while the block is idle. clock_size reports the entry
// count in 5 bits.
module vector_clock_compare_merge #(
	parameter int MAX_NODES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// item input
	input  logic                  req_valid,
	output logic                  req_stall,
	input  vccm_pkg::req_t        req,
	// result output
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output vccm_pkg::rsp_t        rsp,
	// local node tag write
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [63:0]           cfg_data
);
	import vccm_pkg::*;

	localparam int CW = $clog2(MAX_NODES + 1);

	state_t            state_q, state_nxt;
	req_t              op_q;
	logic [TAG_W-1:0]  local_tag_q;
	logic [CW-1:0]     used_q;
	logic              stored_ahead_q;
	logic              remote_ahead_q;
	logic              overflow_q;
	// registered row outputs from the evaluate cycle
	logic              found_q;
	logic [CNT_W-1:0]  sc_q;
	logic              unnamed_q;
	// result register
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              accept;
	logic              need_rsp;
	logic              go;
	logic              upd;
	logic              room;
	logic              append;
	cell_ctl_t         ctl;
	chain_t            chain [MAX_NODES+1];
	logic              sa_fin;

	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign accept    = req_valid && !req_stall;

	// a result is due for everything except a remote entry
	assign need_rsp = (op_q.func != FUNC_REMOTE);
	assign go       = !(need_rsp && rsp_valid_q && rsp_stall);
	assign room     = used_q < CW'(MAX_NODES);
	assign append   = !found_q && room &&
		((op_q.func == FUNC_INCR) || ((op_q.func == FUNC_REMOTE) && op_q.merge));

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_nxt = ST_EVAL;
			end
			ST_EVAL: begin
				state_nxt = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (go) state_nxt = accept ? ST_EVAL : ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		req_stall = 1'b1;
		upd       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
			end
			ST_EVAL: begin
				req_stall = 1'b1;
			end
			ST_UPDATE: begin
				upd       = go;
				req_stall = !go;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	// broadcast to the row of cells
	assign ctl.func      = op_q.func;
	assign ctl.tag       = op_q.node_tag;
	assign ctl.rc        = op_q.remote_count;
	assign ctl.merge     = op_q.merge;
	assign ctl.local_tag = local_tag_q;
	assign ctl.upd       = upd;
	assign ctl.append    = append;

	assign chain[0] = '0;

	for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
		vccm_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.used      (used_q),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1])
		);
	end

	// stored entries never named by the remote clock count as ahead when nonzero
	assign sa_fin = stored_ahead_q | unnamed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_tag_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			local_tag_q <= cfg_data;
		end
	end

	// item and row-result capture (payload)
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= req;
		end
		if (state_q == ST_EVAL) begin
			found_q   <= chain[MAX_NODES].hit;
			sc_q      <= chain[MAX_NODES].cnt;
			unnamed_q <= chain[MAX_NODES].unnamed_nz;
		end
	end

	// clock size and comparison flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q         <= '0;
			stored_ahead_q <= 1'b0;
			remote_ahead_q <= 1'b0;
			overflow_q     <= 1'b0;
		end else if (upd) begin
			case (op_q.func)
				FUNC_RESTART: begin
					used_q         <= CW'(1);
					stored_ahead_q <= 1'b0;
					remote_ahead_q <= 1'b0;
					overflow_q     <= 1'b0;
				end
				FUNC_INCR: begin
					if (append) used_q <= used_q + CW'(1);
				end
				FUNC_REMOTE: begin
					if (sc_q > op_q.remote_count) stored_ahead_q <= 1'b1;
					if (sc_q < op_q.remote_count) remote_ahead_q <= 1'b1;
					if (op_q.merge && !found_q) begin
						if (room) begin
							used_q <= used_q + CW'(1);
						end else begin
							overflow_q <= 1'b1;
						end
					end
				end
				FUNC_FINISH: begin
					stored_ahead_q <= 1'b0;
					remote_ahead_q <= 1'b0;
					overflow_q     <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (upd && need_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd && need_rsp) begin
			case (op_q.func)
				FUNC_RESTART: begin
					rsp_q.status      <= 1'b0;
					rsp_q.order       <= ORDER_EQUAL;
					rsp_q.entry_count <= '0;
					rsp_q.clock_size  <= SIZE_W'(1);
				end
				FUNC_INCR: begin
					rsp_q.order <= ORDER_EQUAL;
					if (found_q) begin
						rsp_q.status      <= 1'b0;
						rsp_q.entry_count <= (sc_q == '1) ? sc_q : sc_q + CNT_W'(1);
					end else if (append) begin
						rsp_q.status      <= 1'b0;
						rsp_q.entry_count <= CNT_W'(1);
					end else begin
						rsp_q.status      <= 1'b1;
						rsp_q.entry_count <= '0;
					end
					rsp_q.clock_size <= SIZE_W'(used_q + CW'(append));
				end
				FUNC_FINISH: begin
					rsp_q.status      <= overflow_q;
					rsp_q.order       <= order_t'({sa_fin, remote_ahead_q});
					rsp_q.entry_count <= '0;
					rsp_q.clock_size  <= SIZE_W'(used_q);
				end
				default: begin
					rsp_q.status      <= 1'b0;
					rsp_q.order       <= ORDER_EQUAL;
					rsp_q.entry_count <= '0;
					rsp_q.clock_size  <= SIZE_W'(used_q);
				end
			endcase
		end
	end

endmodule
